// File: rtl/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int CMD_W           = 3;
   localparam int STATUS_W        = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD  = 3'd0,
      CMD_SUB  = 3'd1,
      CMD_MUL  = 3'd2,
      CMD_DIV  = 3'd3,
      CMD_LT   = 3'd4,
      CMD_NORM = 3'd5,
      CMD_NEG  = 3'd6,
      CMD_NOP  = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_ZDEN = 2'd2,
      ST_RSVD = 2'd3
   } status_type;

endpackage

// File: rtl/rau_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface rau_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/rau_gcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_gcd
// Binary GCD of two magnitudes, one shift or subtract step per cycle.
// ----------------------------------------------------------------------------
module rau_gcd #(
   parameter int W = 33
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic         done,
   output logic [W-1:0] gcd
);
   localparam int SW = $clog2(W + 1);

   logic [W-1:0]  a_ff, a_in, b_ff, b_in;
   logic [SW-1:0] k_ff, k_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   // one binary-gcd step: strip common twos, strip lone twos, subtract
   always_comb begin
      a_in = a_ff; b_in = b_ff; k_in = k_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         a_in = a; b_in = b; k_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (a_ff == '0) begin
            a_in = b_ff; busy_in = 1'b0; done_in = 1'b1;
         end else if (b_ff == '0) begin
            busy_in = 1'b0; done_in = 1'b1;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1; b_in = b_ff >> 1; k_in = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = (a_ff - b_ff) >> 1;
         end else begin
            b_in = (b_ff - a_ff) >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      a_ff <= a_in; b_ff <= b_in; k_ff <= k_in;
   end

   assign done = done_ff;
   assign gcd  = a_ff << k_ff;
endmodule

// File: rtl/rau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div #(
   parameter int W = 33
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  q_ff, q_in, d_ff, d_in;
   logic [W:0]    r_ff, r_in, trial;
   logic [CW-1:0] n_ff, n_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   // shift in one dividend bit and try the subtract
   always_comb begin
      q_in = q_ff; d_in = d_ff; r_in = r_ff; n_in = n_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[W-1:0], q_ff[W-1]};
      if (start) begin
         q_in = dividend; d_in = divisor; r_in = '0;
         n_in = CW'(W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff}; q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = trial; q_in = {q_ff[W-2:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
         if (n_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      q_ff <= q_in; d_ff <= d_in; r_ff <= r_in; n_ff <= n_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

// File: rtl/rational_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Exact fraction add, subtract, multiply, divide, compare, normalize, negate.
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  req       in         command, first_num, first_den, second_num, second_den
//  rsp       out        result_num, result_den, less_than, status
//
//  A request takes three product steps (S_P1, S_P2, S_P3) and a check step,
//  then for reducing commands a start step, a binary GCD and two divisions
//  by it on the shared divider, and a final fit check; the GCD loop and the
//  divider take most of the time. Compare, negate and errors found at the
//  check finish after the check step. Reset is synchronous and clears the
//  sequencer; req_ready is low while busy and while a result waits on rsp.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top #(
   parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   rau_if.sink   req,
   rau_if.source rsp
);
   import rau_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int PW = 2 * W;
   localparam int MW = W + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_P1, S_P2, S_P3, S_CHECK, S_GO, S_GCD, S_DN, S_DD, S_FIN, S_OUT
   } state_type;

   state_type state_ff;
   cmd_type   cmd_ff;
   logic signed [W-1:0]  an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [PW-1:0] p1_ff, p2_ff, d_ff;
   logic signed [PW:0]   n_ff;
   logic [MW-1:0]        g_ff, rn_mag_ff;
   logic                 nneg_ff;
   logic signed [W-1:0]  rnum_ff, rden_ff;
   logic                 lt_ff;
   status_type           st_ff;

   // shared multiplier: operands picked by the step
   logic signed [W-1:0]  ma, mb;
   logic signed [PW-1:0] mp;
   always_comb begin
      ma = an_ff; mb = bd_ff;
      case (state_ff)
         S_P1: begin
            ma = an_ff;
            mb = (cmd_ff == CMD_MUL) ? bn_ff : bd_ff;
         end
         S_P2: begin
            ma = ad_ff;
            mb = (cmd_ff == CMD_DIV) ? bn_ff : bd_ff;
         end
         S_P3: begin ma = bn_ff; mb = ad_ff; end
         default: begin ma = an_ff; mb = bd_ff; end
      endcase
   end
   assign mp = ma * mb;

   function automatic logic fits(input logic signed [PW:0] v);
      logic signed [PW:0] hi, lo;
      begin
         hi = (PW+1)'((64'sd1 <<< (W-1)) - 64'sd1);
         lo = ~hi;
         fits = (v <= hi) && (v >= lo);
      end
   endfunction

   // shared GCD and divider
   logic          gcd_start, gcd_done, div_start, div_done;
   logic [MW-1:0] gcd_a, gcd_b, gcd_g, div_n, div_q;
   logic [PW:0]   n_abs, d_abs;
   assign n_abs = n_ff[PW] ? -n_ff : n_ff;
   assign d_abs = d_ff[PW-1] ? -{d_ff[PW-1], d_ff} : {d_ff[PW-1], d_ff};
   assign gcd_a = n_abs[MW-1:0];
   assign gcd_b = d_abs[MW-1:0];
   assign div_n = (state_ff == S_GCD) ? n_abs[MW-1:0] : d_abs[MW-1:0];

   rau_gcd #(.W(MW)) u_gcd (
      .clock(clock), .reset(reset), .start(gcd_start),
      .a(gcd_a), .b(gcd_b), .done(gcd_done), .gcd(gcd_g)
   );
   rau_div #(.W(MW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_n), .divisor((state_ff == S_GCD) ? gcd_g : g_ff),
      .done(div_done), .quotient(div_q)
   );

   // launch the GCD once the numerator and denominator are registered
   assign gcd_start = (state_ff == S_GO);
   assign div_start = ((state_ff == S_GCD) && gcd_done) ||
                      ((state_ff == S_DN) && div_done);

   logic signed [PW:0] sum_v, neg_v;
   logic signed [MW:0] fn, fd;
   always_comb begin
      sum_v = (cmd_ff == CMD_ADD) ? {p1_ff[PW-1], p1_ff} + {p2_ff[PW-1], p2_ff}
                                  : {p1_ff[PW-1], p1_ff} - {p2_ff[PW-1], p2_ff};
      neg_v = -(PW+1)'(an_ff);
      fn = {1'b0, rn_mag_ff};
      fd = {1'b0, div_q};
      if (nneg_ff) fn = -fn;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data.result_num = rnum_ff;
   assign rsp.data.result_den = rden_ff;
   assign rsp.data.less_than  = lt_ff;
   assign rsp.data.status     = st_ff;

   // sequencer with registered results
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  cmd_ff <= cmd_type'(req.data.command);
                  an_ff <= req.data.first_num;  ad_ff <= req.data.first_den;
                  bn_ff <= req.data.second_num; bd_ff <= req.data.second_den;
                  st_ff <= ST_OK; lt_ff <= 1'b0;
                  rnum_ff <= '0; rden_ff <= W'(1);
                  state_ff <= S_P1;
               end
            end
            S_P1: begin p1_ff <= mp; state_ff <= S_P2; end
            S_P2: begin d_ff <= mp; state_ff <= S_P3; end
            S_P3: begin
               p2_ff <= (cmd_ff == CMD_ADD || cmd_ff == CMD_SUB ||
                         cmd_ff == CMD_LT) ? mp : '0;
               state_ff <= S_CHECK;
               case (cmd_ff)
                  CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                     if (d_ff == '0) st_ff <= ST_ZDEN;
                  end
                  CMD_LT, CMD_NORM, CMD_NEG: begin
                     if (ad_ff == '0 || (cmd_ff == CMD_LT && bd_ff == '0))
                        st_ff <= ST_ZDEN;
                  end
                  default: ;
               endcase
            end
            S_CHECK: begin
               state_ff <= S_OUT;
               n_ff <= sum_v;
               if (st_ff == ST_OK) begin
                  case (cmd_ff)
                     CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                        if (!fits({p1_ff[PW-1], p1_ff}) ||
                            !fits({p2_ff[PW-1], p2_ff}) ||
                            !fits({d_ff[PW-1], d_ff}) ||
                            ((cmd_ff == CMD_ADD || cmd_ff == CMD_SUB) &&
                             !fits(sum_v)))
                           st_ff <= ST_OVF;
                        else begin
                           state_ff <= S_GO;
                           if (cmd_ff == CMD_MUL || cmd_ff == CMD_DIV)
                              n_ff <= {p1_ff[PW-1], p1_ff};
                        end
                     end
                     CMD_LT: lt_ff <= (p1_ff < p2_ff);
                     CMD_NORM: begin
                        n_ff <= (PW+1)'(an_ff);
                        d_ff <= PW'(ad_ff);
                        state_ff <= S_GO;
                     end
                     CMD_NEG: begin
                        if (!fits(neg_v)) st_ff <= ST_OVF;
                        else begin
                           rnum_ff <= neg_v[W-1:0]; rden_ff <= ad_ff;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_GO: state_ff <= S_GCD;
            S_GCD: begin
               if (gcd_done) begin
                  g_ff <= gcd_g;
                  nneg_ff <= n_ff[PW] ^ d_ff[PW-1];
                  state_ff <= S_DN;
               end
            end
            S_DN: begin
               if (div_done) begin
                  rn_mag_ff <= div_q;
                  state_ff <= S_DD;
               end
            end
            S_DD: if (div_done) state_ff <= S_FIN;
            S_FIN: begin
               if (!fits((PW+1)'(fn)) || !fits((PW+1)'(fd))) st_ff <= ST_OVF;
               else begin
                  rnum_ff <= fn[W-1:0]; rden_ff <= fd[W-1:0];
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp.ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // error results are always 0/1
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && st_ff != ST_OK) |-> (rnum_ff == '0 && rden_ff == W'(1) && !lt_ff))
      else $error("error result not 0/1");
   // a good reduced result has a positive denominator
   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && st_ff == ST_OK && cmd_ff != CMD_NEG) |-> (rden_ff > 0))
      else $error("denominator not positive");
   // never accept while a result is held
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("accept during output");
   // compare flag only on compare
   a_lt_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && lt_ff) |-> (cmd_ff == CMD_LT))
      else $error("less_than on non-compare");

endmodule
